@@ src/svp_pkg.sv @@
// ----------------------------------------------------------------------------
// svp_pkg
// Shared constants and types for the Schlegel vertex projection core.
// ----------------------------------------------------------------------------
package svp_pkg;

	localparam int MAX_DIM    = 6;
	localparam int OUT_DIM    = 3;
	localparam int NUM_COORDS = 6;
	localparam int CW         = 32;
	localparam int QBITS      = CW;
	localparam int NLANE      = MAX_DIM - 1;
	localparam int NSTAGE     = MAX_DIM - 2;
	localparam int CNT_W      = $clog2(MAX_DIM + 1);
	localparam int IDX_W      = $clog2(MAX_DIM);
	localparam int DEN_W      = CW + 1;
	localparam int REM_W      = CW + 1;
	localparam int PROD_W     = 2 * CW;
	localparam int SD_W       = 3;
	localparam int FD_W       = 2;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_SOURCE_DIM = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FINAL_DIM  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DISTANCE   = 2'd2;

	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t [MAX_DIM-1:0] vec_t;

	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

	// vertex between projection stages
	typedef struct packed {
		logic zf;
		logic last;
		vec_t v;
	} vtx_t;

	// one divider lane: partial remainder and numerator/quotient shifter
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QBITS-1:0] quo;
		logic             neg;
		logic             ovf;
	} lane_t;

	typedef lane_t [NLANE-1:0] lanes_t;

	// item context carried along the divider cells
	typedef struct packed {
		logic             act;
		logic             zf;
		logic             last;
		vec_t             v;
		logic [DEN_W-1:0] den;
	} cmeta_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		logic   dz;
		logic   last;
	} res_t;

endpackage

@@ src/svp_div_cell.sv @@
// ----------------------------------------------------------------------------
// svp_div_cell
// One restoring-division step for all lanes; passes the item on each cycle that en is high.
// ----------------------------------------------------------------------------
module svp_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            valid_i,
	input  svp_pkg::cmeta_t meta_i,
	input  svp_pkg::lanes_t lanes_i,
	output logic            valid_o,
	output svp_pkg::cmeta_t meta_o,
	output svp_pkg::lanes_t lanes_o
);

	logic [svp_pkg::REM_W:0] t [svp_pkg::NLANE];
	logic                    ge [svp_pkg::NLANE];
	svp_pkg::lanes_t         nxt;
	logic                    valid_q;
	svp_pkg::cmeta_t         meta_q;
	svp_pkg::lanes_t         lanes_q;

	always_comb begin
		for (int i = 0; i < svp_pkg::NLANE; i++) begin
			t[i] = {lanes_i[i].rem, lanes_i[i].quo[svp_pkg::QBITS-1]};
			ge[i] = t[i] >= {1'b0, meta_i.den};
			nxt[i].rem = ge[i] ? svp_pkg::REM_W'(t[i] - {1'b0, meta_i.den})
				: t[i][svp_pkg::REM_W-1:0];
			nxt[i].quo = {lanes_i[i].quo[svp_pkg::QBITS-2:0], ge[i]};
			nxt[i].neg = lanes_i[i].neg;
			nxt[i].ovf = lanes_i[i].ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_q  <= meta_i;
			lanes_q <= nxt;
		end
	end

	assign valid_o = valid_q;
	assign meta_o  = meta_q;
	assign lanes_o = lanes_q;

endmodule

@@ src/svp_stage.sv @@
// ----------------------------------------------------------------------------
// svp_stage
// One projection step: scale lower coordinates by dist/(dist - last coord).
// Multiply, magnitude, setup, a chain of divider cells, then sign/saturate.
// ----------------------------------------------------------------------------
module svp_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [svp_pkg::CNT_W-1:0] cur,
	input  logic [svp_pkg::CNT_W-1:0] sd,
	input  logic [svp_pkg::CNT_W-1:0] fd,
	input  svp_pkg::coord_t           distance,
	input  logic                      valid_i,
	input  svp_pkg::vtx_t             vtx_i,
	output logic                      valid_o,
	output svp_pkg::vtx_t             vtx_o
);

	localparam int PW = svp_pkg::PROD_W;
	localparam int CW = svp_pkg::CW;

	// multiply stage
	logic [svp_pkg::IDX_W-1:0]     cur_m1;
	svp_pkg::coord_t               last_c;
	logic signed [svp_pkg::DEN_W-1:0] den_c;
	logic                          act_c;
	logic                          zero_c;
	logic                          valid_s1;
	logic                          act_s1;
	logic                          zf_s1;
	logic                          last_s1;
	svp_pkg::vec_t                 v_s1;
	logic [svp_pkg::DEN_W-1:0]     den_s1;
	logic signed [PW-1:0]          prod_s1 [svp_pkg::NLANE];

	assign cur_m1 = svp_pkg::IDX_W'(cur - svp_pkg::CNT_W'(1));
	assign last_c = vtx_i.v[cur_m1];
	assign den_c  = {distance[CW-1], distance} - {last_c[CW-1], last_c};
	assign act_c  = valid_i && !vtx_i.zf && (cur <= sd) && (cur > fd);
	assign zero_c = act_c && (den_c == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1  <= act_c && !zero_c;
			zf_s1   <= vtx_i.zf || zero_c;
			last_s1 <= vtx_i.last;
			v_s1    <= vtx_i.v;
			den_s1  <= den_c;
			for (int i = 0; i < svp_pkg::NLANE; i++) begin
				prod_s1[i] <= $signed(vtx_i.v[i]) * $signed(distance);
			end
		end
	end

	// magnitude stage
	logic [PW-1:0]             pneg [svp_pkg::NLANE];
	logic [svp_pkg::DEN_W-1:0] dneg;
	logic                      valid_s2;
	logic                      act_s2;
	logic                      zf_s2;
	logic                      last_s2;
	svp_pkg::vec_t             v_s2;
	logic [svp_pkg::DEN_W-1:0] md_s2;
	logic [PW-2:0]             nm_s2 [svp_pkg::NLANE];
	logic                      neg_s2 [svp_pkg::NLANE];

	always_comb begin
		for (int i = 0; i < svp_pkg::NLANE; i++) begin
			pneg[i] = ~prod_s1[i] + PW'(1);
		end
		dneg = ~den_s1 + svp_pkg::DEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s2  <= act_s1;
			zf_s2   <= zf_s1;
			last_s2 <= last_s1;
			v_s2    <= v_s1;
			md_s2   <= den_s1[svp_pkg::DEN_W-1] ? dneg : den_s1;
			for (int i = 0; i < svp_pkg::NLANE; i++) begin
				nm_s2[i]  <= prod_s1[i][PW-1] ? pneg[i][PW-2:0] : prod_s1[i][PW-2:0];
				neg_s2[i] <= prod_s1[i][PW-1] ^ den_s1[svp_pkg::DEN_W-1];
			end
		end
	end

	// divider setup: quotient of 32 bits fits only if high numerator < divisor
	svp_pkg::lanes_t ln_c;
	svp_pkg::cmeta_t cm_c;
	logic            valid_s3;
	svp_pkg::lanes_t ln_s3;
	svp_pkg::cmeta_t cm_s3;

	always_comb begin
		for (int i = 0; i < svp_pkg::NLANE; i++) begin
			ln_c[i].rem = svp_pkg::REM_W'(nm_s2[i][PW-2:CW]);
			ln_c[i].quo = nm_s2[i][CW-1:0];
			ln_c[i].neg = neg_s2[i];
			ln_c[i].ovf = svp_pkg::REM_W'(nm_s2[i][PW-2:CW]) >= md_s2;
		end
		cm_c.act  = act_s2;
		cm_c.zf   = zf_s2;
		cm_c.last = last_s2;
		cm_c.v    = v_s2;
		cm_c.den  = md_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ln_s3 <= ln_c;
			cm_s3 <= cm_c;
		end
	end

	// divider cell chain
	logic            cvalid [svp_pkg::QBITS+1];
	svp_pkg::cmeta_t cmeta  [svp_pkg::QBITS+1];
	svp_pkg::lanes_t clanes [svp_pkg::QBITS+1];

	assign cvalid[0] = valid_s3;
	assign cmeta[0]  = cm_s3;
	assign clanes[0] = ln_s3;

	for (genvar k = 0; k < svp_pkg::QBITS; k++) begin : g_cell
		svp_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (cvalid[k]),
			.meta_i  (cmeta[k]),
			.lanes_i (clanes[k]),
			.valid_o (cvalid[k+1]),
			.meta_o  (cmeta[k+1]),
			.lanes_o (clanes[k+1])
		);
	end

	// sign and saturation
	svp_pkg::cmeta_t   cm_e;
	svp_pkg::lanes_t   ln_e;
	svp_pkg::vec_t     res_v;
	logic [CW-1:0]     q;
	logic              valid_q;
	svp_pkg::vtx_t     vtx_q;

	assign cm_e = cmeta[svp_pkg::QBITS];
	assign ln_e = clanes[svp_pkg::QBITS];

	always_comb begin
		res_v = cm_e.v;
		q     = '0;
		for (int i = 0; i < svp_pkg::NLANE; i++) begin
			q = ln_e[i].quo;
			if (cm_e.act && ((svp_pkg::CNT_W'(i) + svp_pkg::CNT_W'(1)) < cur)) begin
				if (ln_e[i].ovf) begin
					res_v[i] = ln_e[i].neg ? svp_pkg::C_MIN : svp_pkg::C_MAX;
				end else if (!ln_e[i].neg) begin
					res_v[i] = q[CW-1] ? svp_pkg::C_MAX : svp_pkg::coord_t'(q);
				end else begin
					res_v[i] = (q > {1'b1, {(CW-1){1'b0}}}) ? svp_pkg::C_MIN
						: svp_pkg::coord_t'(~q + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= cvalid[svp_pkg::QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vtx_q.zf   <= cm_e.zf;
			vtx_q.last <= cm_e.last;
			vtx_q.v    <= res_v;
		end
	end

	assign valid_o = valid_q;
	assign vtx_o   = vtx_q;

endmodule

@@ src/schlegel_vertex_projection_core.sv @@
// ----------------------------------------------------------------------------
// schlegel_vertex_projection_core
// Streams vertices through a chain of projection stages, one vertex a clock while not stalled.
// ----------------------------------------------------------------------------
// Input channel: vertex_valid / vertex_stall with coord_0..coord_5 and
// last_vertex; an item is taken when vertex_valid is high and vertex_stall low.
// Output channel: result_valid / result_stall with out_x, out_y, out_z,
// denominator_zero and last_out, one result per vertex, in order.
// Config: cfg_valid / cfg_ready (always ready), cfg_index, cfg_data; write
// only while no vertex is in flight.
// Throughput: one vertex per clock while vertex_stall is low. Each projection
// step is a multiplier stage, two setup stages, 32 divider cells (one quotient
// bit each) and a saturate stage.
// The whole chain advances together; a two-entry output buffer keeps it
// running while one result waits. With the buffer full and result_stall high
// the chain freezes and vertex_stall is raised.
// Reset clears all valid bits and loads source_dim 4, final_dim 3 and a
// projection distance of 2.0; nothing is in flight afterwards.
// ----------------------------------------------------------------------------
module schlegel_vertex_projection_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vertex_valid,
	output logic                          vertex_stall,
	input  logic signed [31:0]            coord_0,
	input  logic signed [31:0]            coord_1,
	input  logic signed [31:0]            coord_2,
	input  logic signed [31:0]            coord_3,
	input  logic signed [31:0]            coord_4,
	input  logic signed [31:0]            coord_5,
	input  logic                          last_vertex,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic signed [31:0]            out_x,
	output logic signed [31:0]            out_y,
	output logic signed [31:0]            out_z,
	output logic                          denominator_zero,
	output logic                          last_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [svp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int CNT_W = svp_pkg::CNT_W;

	logic [svp_pkg::SD_W-1:0] source_dim_q;
	logic [svp_pkg::FD_W-1:0] final_dim_q;
	svp_pkg::coord_t          distance_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_dim_q <= svp_pkg::SD_W'(4);
			final_dim_q  <= svp_pkg::FD_W'(3);
			distance_q   <= 32'sd131072;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				svp_pkg::REG_SOURCE_DIM: source_dim_q <= cfg_data[svp_pkg::SD_W-1:0];
				svp_pkg::REG_FINAL_DIM:  final_dim_q  <= cfg_data[svp_pkg::FD_W-1:0];
				svp_pkg::REG_DISTANCE:   distance_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0] sd_c;
	logic [CNT_W-1:0] fd_c;

	always_comb begin
		if (int'(source_dim_q) < 2) begin
			sd_c = CNT_W'(2);
		end else if (int'(source_dim_q) > svp_pkg::MAX_DIM) begin
			sd_c = CNT_W'(svp_pkg::MAX_DIM);
		end else begin
			sd_c = CNT_W'(source_dim_q);
		end
		if (int'(final_dim_q) < 2) begin
			fd_c = CNT_W'(2);
		end else if (int'(final_dim_q) > svp_pkg::OUT_DIM) begin
			fd_c = CNT_W'(svp_pkg::OUT_DIM);
		end else begin
			fd_c = CNT_W'(final_dim_q);
		end
	end

	// advance control
	logic [1:0] cnt_q;
	logic       en;
	logic       push;
	logic       pop;

	assign en           = (cnt_q != 2'd2) || !result_stall;
	assign vertex_stall = !en;

	// input vertex, coordinates past source_dim read as zero
	svp_pkg::coord_t cin [svp_pkg::NUM_COORDS];
	svp_pkg::vtx_t   vin;

	assign cin[0] = coord_0;
	assign cin[1] = coord_1;
	assign cin[2] = coord_2;
	assign cin[3] = coord_3;
	assign cin[4] = coord_4;
	assign cin[5] = coord_5;

	for (genvar i = 0; i < svp_pkg::MAX_DIM; i++) begin : g_in
		if (i < svp_pkg::NUM_COORDS) begin : g_used
			assign vin.v[i] = (CNT_W'(i) < sd_c) ? cin[i] : '0;
		end else begin : g_zero
			assign vin.v[i] = '0;
		end
	end
	assign vin.zf   = 1'b0;
	assign vin.last = last_vertex;

	// projection chain, highest dimension first
	logic          svalid [svp_pkg::NSTAGE+1];
	svp_pkg::vtx_t svtx   [svp_pkg::NSTAGE+1];

	assign svalid[0] = vertex_valid && !vertex_stall;
	assign svtx[0]   = vin;

	for (genvar k = 0; k < svp_pkg::NSTAGE; k++) begin : g_stage
		svp_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.cur      (CNT_W'(svp_pkg::MAX_DIM - k)),
			.sd       (sd_c),
			.fd       (fd_c),
			.distance (distance_q),
			.valid_i  (svalid[k]),
			.vtx_i    (svtx[k]),
			.valid_o  (svalid[k+1]),
			.vtx_o    (svtx[k+1])
		);
	end

	// result formatting
	svp_pkg::vtx_t vend;
	svp_pkg::res_t res_c;

	assign vend       = svtx[svp_pkg::NSTAGE];
	assign res_c.x    = vend.zf ? '0 : vend.v[0];
	assign res_c.y    = vend.zf ? '0 : vend.v[1];
	assign res_c.z    = (vend.zf || (fd_c < CNT_W'(3))) ? '0 : vend.v[2];
	assign res_c.dz   = vend.zf;
	assign res_c.last = vend.last;

	// two-entry output buffer
	svp_pkg::res_t buf0_q;
	svp_pkg::res_t buf1_q;

	assign push = en && svalid[svp_pkg::NSTAGE];
	assign pop  = (cnt_q != 2'd0) && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (push && (cnt_q == 2'd1)) begin
				buf0_q <= res_c;
			end else begin
				buf0_q <= buf1_q;
			end
			if (push && (cnt_q == 2'd2)) begin
				buf1_q <= res_c;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				buf0_q <= res_c;
			end else begin
				buf1_q <= res_c;
			end
		end
	end

	assign result_valid     = (cnt_q != 2'd0);
	assign out_x            = buf0_q.x;
	assign out_y            = buf0_q.y;
	assign out_z            = buf0_q.z;
	assign denominator_zero = buf0_q.dz;
	assign last_out         = buf0_q.last;

endmodule

@@ tb/svp_projection_checker.sv @@
// ----------------------------------------------------------------------------
// svp_projection_checker
// Watches the vertex, result and register channels of the projection core.
// It keeps its own copy of the registers, works out the projected result of
// every vertex it sees accepted, and compares results in order.
// ----------------------------------------------------------------------------
module svp_projection_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vertex_valid,
	input  logic                          vertex_stall,
	input  logic signed [31:0]            coord_0,
	input  logic signed [31:0]            coord_1,
	input  logic signed [31:0]            coord_2,
	input  logic signed [31:0]            coord_3,
	input  logic signed [31:0]            coord_4,
	input  logic signed [31:0]            coord_5,
	input  logic                          last_vertex,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic signed [31:0]            out_x,
	input  logic signed [31:0]            out_y,
	input  logic signed [31:0]            out_z,
	input  logic                          denominator_zero,
	input  logic                          last_out,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [svp_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import svp_pkg::*;

	logic [SD_W-1:0] src_dim;
	logic [FD_W-1:0] dst_dim;
	coord_t          proj_dist;
	res_t            projected_q[$];

	assign pending = projected_q.size();

	function automatic longint clamp32(longint a);
		if (a > longint'(C_MAX))
			return longint'(C_MAX);
		if (a < longint'(C_MIN))
			return longint'(C_MIN);
		return a;
	endfunction

	function automatic res_t project_vertex(coord_t c0, coord_t c1, coord_t c2,
			coord_t c3, coord_t c4, coord_t c5, logic lst);
		longint v[MAX_DIM];
		coord_t c[NUM_COORDS];
		longint d;
		longint den;
		int sd;
		int fd;
		logic hit_zero;
		res_t r;
		c = '{c0, c1, c2, c3, c4, c5};
		d = longint'(proj_dist);
		sd = int'(src_dim);
		fd = int'(dst_dim);
		hit_zero = 1'b0;
		if (sd < 2) sd = 2;
		if (sd > MAX_DIM) sd = MAX_DIM;
		if (fd < 2) fd = 2;
		if (fd > OUT_DIM) fd = OUT_DIM;
		for (int i = 0; i < MAX_DIM; i++)
			v[i] = (i < sd && i < NUM_COORDS) ? longint'(c[i]) : 0;
		for (int k = sd; k > fd; k--) begin
			den = d - v[k-1];
			if (den == 0) begin
				hit_zero = 1'b1;
				break;
			end
			for (int i = 0; i < k - 1; i++)
				v[i] = clamp32((v[i] * d) / den);
		end
		r.x    = hit_zero ? '0 : coord_t'(v[0]);
		r.y    = hit_zero ? '0 : coord_t'(v[1]);
		r.z    = (hit_zero || fd < 3) ? '0 : coord_t'(v[2]);
		r.dz   = hit_zero;
		r.last = lst;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			src_dim    <= 3'd4;
			dst_dim    <= 2'd3;
			proj_dist  <= 32'sd131072;
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SOURCE_DIM: src_dim   <= cfg_data[SD_W-1:0];
					REG_FINAL_DIM:  dst_dim   <= cfg_data[FD_W-1:0];
					REG_DISTANCE:   proj_dist <= cfg_data;
					default: ;
				endcase
			end
			if (vertex_valid && !vertex_stall)
				projected_q.push_back(project_vertex(coord_0, coord_1, coord_2,
					coord_3, coord_4, coord_5, last_vertex));
			if (result_valid && !result_stall) begin
				if (projected_q.size() == 0) begin
					fail_count++;
					$display("%0t: result item with nothing expected: x=%0d y=%0d z=%0d dz=%0b last=%0b",
						$time, out_x, out_y, out_z, denominator_zero, last_out);
				end else begin
					want = projected_q.pop_front();
					if (want.x !== out_x || want.y !== out_y || want.z !== out_z ||
							want.dz !== denominator_zero || want.last !== last_out) begin
						fail_count++;
						$display("%0t: mismatch expected x=%0d y=%0d z=%0d dz=%0b last=%0b",
							$time, want.x, want.y, want.z, want.dz, want.last);
						$display("%0t:          actual   x=%0d y=%0d z=%0d dz=%0b last=%0b",
							$time, out_x, out_y, out_z, denominator_zero, last_out);
					end
				end
			end
		end
	end

endmodule

@@ tb/tb_schlegel_vertex_projection_core.sv @@
// ----------------------------------------------------------------------------
// tb_schlegel_vertex_projection_core
// Drives vertices through the projection core under a series of register
// settings (defaults, clamped dimensions, pass-through, extreme distances),
// with random gaps on the sender and random stalls on the receiver.
// ----------------------------------------------------------------------------
module tb_schlegel_vertex_projection_core;
	timeunit 1ns;
	timeprecision 1ps;

	import svp_pkg::*;

	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam int DRAIN_CYCLES  = 160;
	localparam int STALL_LIMIT   = 5000;
	localparam int PHASES        = 12;
	localparam int PHASE_ITEMS   = 125;

	logic           clk;
	logic           arst_n;
	logic           vertex_valid;
	logic           vertex_stall;
	coord_t         vtx [NUM_COORDS];
	logic           last_vertex;
	logic           result_valid;
	logic           result_stall;
	coord_t         out_x, out_y, out_z;
	logic           denominator_zero;
	logic           last_out;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [31:0]    cfg_data;
	int             fail_count;
	int             pending;
	int             quiet_cycles;
	logic           calm;
	coord_t         cur_dist;

	schlegel_vertex_projection_core i_dut (
		.clk, .arst_n,
		.vertex_valid, .vertex_stall,
		.coord_0(vtx[0]), .coord_1(vtx[1]), .coord_2(vtx[2]),
		.coord_3(vtx[3]), .coord_4(vtx[4]), .coord_5(vtx[5]),
		.last_vertex,
		.result_valid, .result_stall,
		.out_x, .out_y, .out_z, .denominator_zero, .last_out,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	svp_projection_checker i_checker (
		.clk, .arst_n,
		.vertex_valid, .vertex_stall,
		.coord_0(vtx[0]), .coord_1(vtx[1]), .coord_2(vtx[2]),
		.coord_3(vtx[3]), .coord_4(vtx[4]), .coord_5(vtx[5]),
		.last_vertex,
		.result_valid, .result_stall,
		.out_x, .out_y, .out_z, .denominator_zero, .last_out,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .pending
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// receiver stalls; none while calm
	always @(posedge clk)
		result_stall <= !calm && ($urandom_range(99) < 19);

	always @(posedge clk) begin
		if ((vertex_valid && !vertex_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic wait_idle();
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_vertex(coord_t c0, coord_t c1, coord_t c2, coord_t c3,
			coord_t c4, coord_t c5, logic lst);
		if (!calm && $urandom_range(99) < 19) begin
			vertex_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 40);
		end
		vertex_valid <= 1'b1;
		vtx[0] <= c0; vtx[1] <= c1; vtx[2] <= c2;
		vtx[3] <= c3; vtx[4] <= c4; vtx[5] <= c5;
		last_vertex <= lst;
		do @(posedge clk); while (vertex_stall);
	endtask

	function automatic coord_t pick_coord();
		int mode;
		mode = $urandom_range(9);
		if (mode < 4)
			return coord_t'($signed($urandom_range(524288)) - 262144);
		if (mode == 4)
			return cur_dist;
		if (mode == 5)
			return cur_dist + coord_t'($signed($urandom_range(2)) - 1);
		if (mode == 6)
			return $urandom_range(1) ? C_MAX : C_MIN;
		return coord_t'($urandom);
	endfunction

	initial begin
		logic [2:0]  sd_set [PHASES];
		logic [1:0]  fd_set [PHASES];
		logic [31:0] dist_set [PHASES];
		arst_n       = 1'b0;
		vertex_valid = 1'b0;
		last_vertex  = 1'b0;
		result_stall = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		quiet_cycles = 0;
		calm         = 1'b0;
		cur_dist     = 32'sd131072;
		foreach (vtx[i]) vtx[i] = '0;

		// phase 0 keeps reset values; clamped and pass-through dims follow
		sd_set   = '{3'd4, 3'd2, 3'd6, 3'd7, 3'd0, 3'd5, 3'd3, 3'd6,
			3'd1, 3'd4, 3'd6, 3'd5};
		fd_set   = '{2'd3, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd2, 2'd3,
			2'd2, 2'd2, 2'd3, 2'd2};
		dist_set = '{32'd131072, $urandom, 32'd65536, 32'h7fffffff, 32'h80000000,
			32'd0, 32'hfffe0000, 32'd1, 32'hffffffff, $urandom, $urandom, 32'd327680};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed vertices under reset settings
		put_vertex('0, '0, '0, '0, '0, '0, 1'b0);
		put_vertex(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1);
		put_vertex(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b0);
		put_vertex(32'sd65536, -32'sd65536, 32'sd100, 32'sd131072, '0, '0, 1'b1);
		put_vertex(C_MAX, C_MIN, 32'sd7, 32'sd131071, '0, '0, 1'b0);
		put_vertex(32'sd65536, 32'sd65536, 32'sd131072, 32'sd65536, '0, '0, 1'b0);
		put_vertex(32'sd65536, 32'sd3, -32'sd5, -32'sd131072, C_MAX, C_MIN, 1'b1);
		put_vertex(-32'sd12345, 32'sd9876, C_MAX, C_MIN, 32'sd1, 32'sd2, 1'b0);
		put_vertex(32'sd1, -32'sd1, 32'sd1, 32'sd131073, 32'sd5, 32'sd5, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				vertex_valid <= 1'b0;
				wait_idle();
				write_reg(REG_SOURCE_DIM, {29'($urandom), sd_set[p]});
				write_reg(REG_FINAL_DIM, {30'($urandom), fd_set[p]});
				write_reg(REG_DISTANCE, dist_set[p]);
				if (p % 3 == 1)
					write_reg(REG_UNMAPPED, $urandom);
				cfg_valid <= 1'b0;
				cur_dist = coord_t'(dist_set[p]);
			end
			calm = (p == 6);
			for (int n = 0; n < PHASE_ITEMS; n++)
				put_vertex(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
					pick_coord(), pick_coord(), 1'($urandom));
		end
		vertex_valid <= 1'b0;
		calm = 1'b0;
		wait_idle();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
